>>> rtl/asbp_pkg.sv
// Package for the accelerometer sample bit packer.
// Holds word types, register indexes, reset values and the orientation decoder.
// No dependencies.
`default_nettype none

package asbp_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int MAX_RESULTS         = 4;
    localparam int CFG_DATA_W          = 8;
    localparam int CFG_INDEX_W         = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_RESOLUTION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY    = 2'd2;

    localparam logic [4:0] RESOLUTION_RESET  = 5'd10;
    localparam logic [6:0] ORIENTATION_RESET = 7'd20;
    localparam logic [7:0] CAPACITY_RESET    = 8'd16;

    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_START    = 1'b1;
    localparam logic RESULT_DATA   = 1'b0;
    localparam logic RESULT_HEADER = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  axes_mask;
        logic [15:0] run_length;
        logic [15:0] raw_axis_zero;
        logic [15:0] raw_axis_one;
        logic [15:0] raw_axis_two;
        logic        sensor_overflow;
        logic [15:0] measured_rate;
    } sample_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] packed_word;
        logic [15:0] first_sample_index;
        logic [7:0]  packet_sample_count;
        logic [15:0] reported_rate;
        logic        overflow_seen;
        logic        final_packet;
        logic        orientation_bad;
        logic        last_of_item;
    } result_word_t;

    typedef struct packed {
        logic            bad;
        logic [2:0][1:0] axis_map;
        logic [2:0]      invert;
    } orient_t;

    function automatic orient_t decode_orientation(input logic [6:0] code);
        orient_t    o;
        logic [2:0] zd;
        logic [6:0] xd;
        logic [1:0] xo;
        logic [1:0] zo;
        logic [1:0] yo;
        logic [1:0] xo_next;
        logic       xi;
        logic       zi;
        logic       yi;
        o.bad = 1'b0;
        o.axis_map = {2'd2, 2'd1, 2'd0};
        o.invert = 3'b000;
        if (code >= 7'd60) zd = 3'd6;
        else if (code >= 7'd50) zd = 3'd5;
        else if (code >= 7'd40) zd = 3'd4;
        else if (code >= 7'd30) zd = 3'd3;
        else if (code >= 7'd20) zd = 3'd2;
        else if (code >= 7'd10) zd = 3'd1;
        else zd = 3'd0;
        xd = code - {4'd0, zd} * 7'd10;
        xo = xd[1:0];
        zo = zd[1:0];
        xi = xd[2];
        zi = zd[2];
        yo = 2'd3 - xo - zo;
        xo_next = (xo == 2'd2) ? 2'd0 : xo + 2'd1;
        yi = xi ^ zi ^ (xo_next != yo);
        if (code >= 7'd70 || xd >= 7'd7 || xo == 2'd3 || zo == 2'd3 || xo == zo)
        begin
            o.bad = 1'b1;
        end
        else
        begin
            o.axis_map[xo] = 2'd0;
            o.axis_map[yo] = 2'd1;
            o.axis_map[zo] = 2'd2;
            o.invert[xo] = xi;
            o.invert[yo] = yi;
            o.invert[zo] = zi;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/accel_sample_bit_packer_top.sv
// Accelerometer sample bit packer, top level.
// Uses asbp_pkg for word types, register indexes and the orientation decoder.
//
//   channel   | direction | handshake                    | payload
//   sample    | in        | sample_valid / sample_ready  | asbp_pkg::sample_word_t
//   result    | out       | result_valid / result_ready  | asbp_pkg::result_word_t
//   cfg       | in        | cfg_write                    | cfg_index, cfg_data
//
// A sample word is processed in the cycle it is accepted; its zero to four results
// go to the output batch, or to a holding batch while the output batch still drains,
// and leave one result per cycle while result_ready is high.
// Sustained rate is one result per cycle while result_ready stays high.
// sample_ready drops while the holding batch is full, until the output batch empties.
// Reset clears all run state and restores the register reset values.
`default_nettype none

module accel_sample_bit_packer_top #(
    parameter int COUNT_WIDTH = asbp_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire asbp_pkg::sample_word_t            sample_data,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output asbp_pkg::result_word_t                 result_data,
    input  wire logic                              cfg_write,
    input  wire logic [asbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [asbp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [4:0]             resolution_reg;
    logic [6:0]             orientation_reg;
    logic [7:0]             capacity_reg;

    logic                   run_active_reg;
    logic                   run_active_next;
    logic [2:0]             req_axes_reg;
    logic [2:0]             req_axes_next;
    logic [COUNT_WIDTH-1:0] samples_left_reg;
    logic [COUNT_WIDTH-1:0] samples_left_next;
    logic [COUNT_WIDTH-1:0] samples_done_reg;
    logic [COUNT_WIDTH-1:0] samples_done_next;
    logic [7:0]             pkt_samples_reg;
    logic [7:0]             pkt_samples_next;
    logic [15:0]            pend_bits_reg;
    logic [15:0]            pend_bits_next;
    logic [3:0]             pend_count_reg;
    logic [3:0]             pend_count_next;
    logic                   ovf_sticky_reg;
    logic                   ovf_sticky_next;
    logic                   discarded_reg;
    logic                   discarded_next;

    asbp_pkg::result_word_t [asbp_pkg::MAX_RESULTS-1:0] hold_res_reg;
    logic                   hold_vld_reg;
    logic [2:0]             hold_cnt_reg;
    asbp_pkg::result_word_t [asbp_pkg::MAX_RESULTS-1:0] out_res_reg;
    logic [2:0]             out_cnt_reg;

    asbp_pkg::orient_t      orient;
    logic [4:0]             res_eff;
    logic [7:0]             cap_eff;
    logic [2:0][15:0]       raw_sel;
    logic [2:0][15:0]       val_adj;
    logic [2:0][15:0]       val_just;
    logic [5:0]             off1;
    logic [5:0]             off2;
    logic [5:0]             total_bits;
    logic [3:0][15:0]       acc_words;
    logic [1:0]             word_cnt;
    logic [15:0]            leftover;
    logic [7:0]             pkt_inc;
    logic [COUNT_WIDTH-1:0] left_dec;
    logic [IDX_W-1:0]       done_ext;
    logic                   fin;
    logic                   hdr;
    logic                   accept;
    logic                   process;
    logic [2:0]             batch_cnt;
    logic                   new_batch;
    asbp_pkg::result_word_t [asbp_pkg::MAX_RESULTS-1:0] batch;
    logic                   out_pop;
    logic                   out_free;

    // Orientation and clamped settings
    always_comb
    begin
        orient = asbp_pkg::decode_orientation(orientation_reg);
        if (resolution_reg == 5'd0)
            res_eff = 5'd1;
        else if (resolution_reg > 5'd16)
            res_eff = 5'd16;
        else
            res_eff = resolution_reg;
        cap_eff = (capacity_reg == 8'd0) ? 8'd1 : capacity_reg;
    end

    // Remap, invert, right-justify and pack
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            case (orient.axis_map[a])
                2'd0:    raw_sel[a] = sample_data.raw_axis_zero;
                2'd1:    raw_sel[a] = sample_data.raw_axis_one;
                default: raw_sel[a] = sample_data.raw_axis_two;
            endcase
            if (orient.invert[a])
                val_adj[a] = (raw_sel[a] == 16'h8000) ? 16'h7FFF : 16'd0 - raw_sel[a];
            else
                val_adj[a] = raw_sel[a];
            val_just[a] = req_axes_reg[a] ? (val_adj[a] >> (5'd16 - res_eff)) : 16'd0;
        end
        off1 = {2'd0, pend_count_reg} + (req_axes_reg[0] ? {1'b0, res_eff} : 6'd0);
        off2 = off1 + (req_axes_reg[1] ? {1'b0, res_eff} : 6'd0);
        total_bits = off2 + (req_axes_reg[2] ? {1'b0, res_eff} : 6'd0);
        acc_words = {48'd0, pend_bits_reg}
                  | ({48'd0, val_just[0]} << pend_count_reg)
                  | ({48'd0, val_just[1]} << off1)
                  | ({48'd0, val_just[2]} << off2);
        word_cnt = total_bits[5:4];
        leftover = acc_words[word_cnt];
    end

    // Run bookkeeping
    always_comb
    begin
        accept   = sample_valid && sample_ready;
        pkt_inc  = pkt_samples_reg + 8'd1;
        left_dec = samples_left_reg - COUNT_WIDTH'(1);
        done_ext = IDX_W'(samples_done_reg);
        fin      = (left_dec == '0);
        hdr      = (pkt_inc >= cap_eff) || (pkt_inc == 8'd0) || fin;
        process  = accept && (sample_data.kind == asbp_pkg::KIND_SAMPLE)
                && run_active_reg && discarded_reg;

        run_active_next   = run_active_reg;
        req_axes_next     = req_axes_reg;
        samples_left_next = samples_left_reg;
        samples_done_next = samples_done_reg;
        pkt_samples_next  = pkt_samples_reg;
        pend_bits_next    = pend_bits_reg;
        pend_count_next   = pend_count_reg;
        ovf_sticky_next   = ovf_sticky_reg;
        discarded_next    = discarded_reg;

        if (accept && sample_data.kind == asbp_pkg::KIND_START && !run_active_reg)
        begin
            req_axes_next     = sample_data.axes_mask;
            samples_left_next = COUNT_WIDTH'(sample_data.run_length);
            samples_done_next = '0;
            pkt_samples_next  = 8'd0;
            pend_bits_next    = 16'd0;
            pend_count_next   = 4'd0;
            ovf_sticky_next   = 1'b0;
            discarded_next    = 1'b0;
            run_active_next   = (sample_data.run_length != 16'd0)
                             && (COUNT_WIDTH'(sample_data.run_length) != '0);
        end
        else if (accept && sample_data.kind == asbp_pkg::KIND_SAMPLE && run_active_reg)
        begin
            ovf_sticky_next = ovf_sticky_reg | sample_data.sensor_overflow;
            if (!discarded_reg)
            begin
                discarded_next = 1'b1;
            end
            else
            begin
                samples_left_next = left_dec;
                if (hdr)
                begin
                    samples_done_next = samples_done_reg + COUNT_WIDTH'(pkt_inc);
                    pkt_samples_next  = 8'd0;
                    pend_bits_next    = 16'd0;
                    pend_count_next   = 4'd0;
                    ovf_sticky_next   = 1'b0;
                    run_active_next   = !fin;
                end
                else
                begin
                    pkt_samples_next = pkt_inc;
                    pend_bits_next   = leftover;
                    pend_count_next  = total_bits[3:0];
                end
            end
        end
    end

    // Result batch for one sample
    always_comb
    begin
        batch_cnt = {1'b0, word_cnt} + {2'd0, hdr};
        new_batch = process && (batch_cnt != 3'd0);
        for (int k = 0; k < asbp_pkg::MAX_RESULTS; k++)
        begin
            batch[k] = '0;
            batch[k].orientation_bad = orient.bad;
            batch[k].last_of_item = (3'(k) == batch_cnt - 3'd1);
            if (3'(k) < {1'b0, word_cnt})
            begin
                batch[k].result_kind = asbp_pkg::RESULT_DATA;
                batch[k].packed_word = acc_words[k];
            end
            else
            begin
                batch[k].result_kind         = asbp_pkg::RESULT_HEADER;
                batch[k].packed_word         = leftover;
                batch[k].first_sample_index  = done_ext[15:0];
                batch[k].packet_sample_count = pkt_inc;
                batch[k].reported_rate       = sample_data.measured_rate;
                batch[k].overflow_seen       = ovf_sticky_reg | sample_data.sensor_overflow;
                batch[k].final_packet        = fin;
            end
        end
    end

    assign sample_ready = !hold_vld_reg;
    assign result_valid = (out_cnt_reg != 3'd0);
    assign result_data  = out_res_reg[0];
    assign out_pop      = result_valid && result_ready;
    assign out_free     = (out_cnt_reg == 3'd0) || (out_pop && out_cnt_reg == 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg   <= asbp_pkg::RESOLUTION_RESET;
            orientation_reg  <= asbp_pkg::ORIENTATION_RESET;
            capacity_reg     <= asbp_pkg::CAPACITY_RESET;
            run_active_reg   <= 1'b0;
            req_axes_reg     <= 3'd0;
            samples_left_reg <= '0;
            samples_done_reg <= '0;
            pkt_samples_reg  <= 8'd0;
            pend_bits_reg    <= 16'd0;
            pend_count_reg   <= 4'd0;
            ovf_sticky_reg   <= 1'b0;
            discarded_reg    <= 1'b0;
            hold_vld_reg     <= 1'b0;
            hold_cnt_reg     <= 3'd0;
            out_cnt_reg      <= 3'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    asbp_pkg::REG_RESOLUTION:  resolution_reg  <= cfg_data[4:0];
                    asbp_pkg::REG_ORIENTATION: orientation_reg <= cfg_data[6:0];
                    asbp_pkg::REG_CAPACITY:    capacity_reg    <= cfg_data[7:0];
                    default:                   ;
                endcase
            end
            run_active_reg   <= run_active_next;
            req_axes_reg     <= req_axes_next;
            samples_left_reg <= samples_left_next;
            samples_done_reg <= samples_done_next;
            pkt_samples_reg  <= pkt_samples_next;
            pend_bits_reg    <= pend_bits_next;
            pend_count_reg   <= pend_count_next;
            ovf_sticky_reg   <= ovf_sticky_next;
            discarded_reg    <= discarded_next;

            if (out_free)
            begin
                if (hold_vld_reg)
                begin
                    out_cnt_reg  <= hold_cnt_reg;
                    hold_vld_reg <= new_batch;
                    hold_cnt_reg <= batch_cnt;
                end
                else
                begin
                    out_cnt_reg <= new_batch ? batch_cnt : 3'd0;
                end
            end
            else
            begin
                if (out_pop)
                    out_cnt_reg <= out_cnt_reg - 3'd1;
                if (new_batch)
                begin
                    hold_vld_reg <= 1'b1;
                    hold_cnt_reg <= batch_cnt;
                end
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (hold_vld_reg)
            begin
                out_res_reg <= hold_res_reg;
                if (new_batch)
                    hold_res_reg <= batch;
            end
            else if (new_batch)
            begin
                out_res_reg <= batch;
            end
        end
        else
        begin
            if (out_pop)
            begin
                for (int i = 0; i < asbp_pkg::MAX_RESULTS - 1; i++)
                    out_res_reg[i] <= out_res_reg[i+1];
            end
            if (new_batch)
                hold_res_reg <= batch;
        end
    end

    a_out_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= 3'(asbp_pkg::MAX_RESULTS))
        else $error("output batch count out of range");

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_vld_reg |-> (out_cnt_reg != 3'd0))
        else $error("holding batch filled while output batch empty");

    a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        !run_active_reg |-> (samples_left_reg == '0 && pkt_samples_reg == 8'd0
                             && pend_count_reg == 4'd0))
        else $error("idle with run counters not cleared");

    a_no_batch_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_vld_reg && !out_free) |=> $stable(hold_cnt_reg))
        else $error("holding batch overwritten");

endmodule

`default_nettype wire

>>> sim/asbp_result_checker.sv
// Result checker for the accelerometer sample bit packer.
// Watches the sample, result and cfg ports, packs accepted samples itself and
// compares every result word in order. Depends on asbp_pkg.
module asbp_result_checker
    import asbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic                   sample_ready,
    input  sample_word_t           sample_data,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  result_word_t           result_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     expected_count,
    output int                     fail_count
);

    localparam int PRINT_LIMIT = 40;

    logic [4:0]   resolution_reg;
    logic [6:0]   orientation_reg;
    logic [7:0]   capacity_reg;

    logic         run_on;
    logic [2:0]   axes_sel;
    logic [15:0]  left_cnt;
    logic [15:0]  done_cnt;
    logic [7:0]   in_packet;
    logic [31:0]  acc_bits;
    int unsigned  acc_len;
    logic         ovf_flag;
    logic         primed;
    logic [15:0]  last_rate;

    result_word_t due_results[$];
    int           errors;

    task automatic report(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("%0t asbp_result_checker: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    function automatic logic orientation_invalid(input logic [6:0] code,
                                                 output logic [2:0][1:0] src,
                                                 output logic [2:0] flip);
        int unsigned c;
        int unsigned units;
        int unsigned tens;
        int unsigned xs;
        int unsigned zs;
        int unsigned ys;
        logic        xf;
        logic        zf;
        logic        yf;
        src = {2'd2, 2'd1, 2'd0};
        flip = 3'b000;
        c = code;
        if (c >= 70) return 1'b1;
        units = c % 10;
        tens = c / 10;
        if (units >= 7) return 1'b1;
        xs = units & 3;
        zs = tens & 3;
        if (xs == 3 || zs == 3 || xs == zs) return 1'b1;
        xf = (units & 4) != 0;
        zf = (tens & 4) != 0;
        yf = xf ^ zf;
        ys = 3 - xs - zs;
        if ((xs + 1) % 3 != ys) yf = ~yf;
        src[xs] = 2'd0;
        flip[xs] = xf;
        src[ys] = 2'd1;
        flip[ys] = yf;
        src[zs] = 2'd2;
        flip[zs] = zf;
        return 1'b0;
    endfunction

    task automatic pack_sample_word(input sample_word_t w);
        logic [2:0][1:0] src;
        logic [2:0]      flip;
        logic            bad;
        int unsigned     bits;
        int unsigned     cap;
        int unsigned     start_size;
        int              a;
        logic [15:0]     raw [3];
        logic [31:0]     v;
        logic            fin;
        result_word_t    r;
        start_size = due_results.size();
        if (w.kind == KIND_START)
        begin
            if (run_on) return;
            axes_sel = w.axes_mask;
            left_cnt = w.run_length;
            done_cnt = '0;
            in_packet = '0;
            acc_bits = '0;
            acc_len = 0;
            ovf_flag = 1'b0;
            primed = 1'b0;
            last_rate = '0;
            run_on = (w.run_length != 16'd0);
            return;
        end
        if (!run_on) return;
        ovf_flag = ovf_flag | w.sensor_overflow;
        last_rate = w.measured_rate;
        if (!primed)
        begin
            primed = 1'b1;
            return;
        end
        bad = orientation_invalid(orientation_reg, src, flip);
        bits = resolution_reg;
        if (bits < 1) bits = 1;
        if (bits > 16) bits = 16;
        cap = (capacity_reg == 8'd0) ? 1 : capacity_reg;
        raw[0] = w.raw_axis_zero;
        raw[1] = w.raw_axis_one;
        raw[2] = w.raw_axis_two;
        for (a = 0; a < 3; a++)
        begin
            if (!axes_sel[a]) continue;
            v = {16'd0, raw[src[a]]};
            if (flip[a]) v = (v == 32'h8000) ? 32'h7FFF : ((~v + 32'd1) & 32'hFFFF);
            v = v >> (16 - bits);
            acc_bits = acc_bits | (v << acc_len);
            acc_len = acc_len + bits;
            if (acc_len >= 16)
            begin
                r = '0;
                r.result_kind = RESULT_DATA;
                r.packed_word = acc_bits[15:0];
                r.orientation_bad = bad;
                due_results.push_back(r);
                acc_len = acc_len - 16;
                acc_bits = v >> (bits - acc_len);
            end
        end
        in_packet = in_packet + 8'd1;
        left_cnt = left_cnt - 16'd1;
        fin = (left_cnt == 16'd0);
        if (in_packet >= cap || in_packet == 8'd0 || fin)
        begin
            r = '0;
            r.result_kind = RESULT_HEADER;
            r.packed_word = (acc_len != 0) ? acc_bits[15:0] : 16'd0;
            r.first_sample_index = done_cnt;
            r.packet_sample_count = in_packet;
            r.reported_rate = last_rate;
            r.overflow_seen = ovf_flag;
            r.final_packet = fin;
            r.orientation_bad = bad;
            due_results.push_back(r);
            done_cnt = done_cnt + {8'd0, in_packet};
            in_packet = '0;
            acc_bits = '0;
            acc_len = 0;
            ovf_flag = 1'b0;
            if (fin) run_on = 1'b0;
        end
        if (due_results.size() > start_size)
        begin
            r = due_results.pop_back();
            r.last_of_item = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic match_result(input result_word_t got);
        result_word_t want;
        if (due_results.size() == 0)
        begin
            report($sformatf("result %h with none expected", got));
            return;
        end
        want = due_results.pop_front();
        check_field("result_kind", got.result_kind, want.result_kind);
        check_field("packed_word", got.packed_word, want.packed_word);
        check_field("first_sample_index", got.first_sample_index, want.first_sample_index);
        check_field("packet_sample_count", got.packet_sample_count, want.packet_sample_count);
        check_field("reported_rate", got.reported_rate, want.reported_rate);
        check_field("overflow_seen", got.overflow_seen, want.overflow_seen);
        check_field("final_packet", got.final_packet, want.final_packet);
        check_field("orientation_bad", got.orientation_bad, want.orientation_bad);
        check_field("last_of_item", got.last_of_item, want.last_of_item);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg = RESOLUTION_RESET;
            orientation_reg = ORIENTATION_RESET;
            capacity_reg = CAPACITY_RESET;
            run_on = 1'b0;
            axes_sel = '0;
            left_cnt = '0;
            done_cnt = '0;
            in_packet = '0;
            acc_bits = '0;
            acc_len = 0;
            ovf_flag = 1'b0;
            primed = 1'b0;
            last_rate = '0;
            due_results.delete();
            errors = 0;
            expected_count <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (result_valid && result_ready) match_result(result_data);
            if (sample_valid && sample_ready) pack_sample_word(sample_data);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RESOLUTION:  resolution_reg = cfg_data[4:0];
                    REG_ORIENTATION: orientation_reg = cfg_data[6:0];
                    REG_CAPACITY:    capacity_reg = cfg_data[7:0];
                    default:         ;
                endcase
            end
            expected_count <= due_results.size();
            fail_count <= errors;
        end
    end

endmodule

>>> sim/accel_sample_bit_packer_top_tb.sv
// Testbench top for accel_sample_bit_packer_top.
// Drives runs of sample words through several register settings with random
// bursts and output stalls; asbp_result_checker does the checking.
module accel_sample_bit_packer_top_tb;
    import asbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 46;

    localparam int READY_ALWAYS   = 0;
    localparam int READY_HALF     = 1;
    localparam int READY_MOSTLY   = 2;
    localparam int READY_PERIODIC = 3;

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_ready;
    sample_word_t           sample_data;
    logic                   result_valid;
    logic                   result_ready;
    result_word_t           result_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     expected_count;
    int                     fail_count;
    int                     hold_token;
    int                     burst_left;
    int                     run_left;
    int                     idle_cycles;

    accel_sample_bit_packer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    asbp_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample_data    (sample_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .expected_count (expected_count),
        .fail_count     (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic sample_word_t sample_of(input logic [15:0] a0, input logic [15:0] a1,
                                               input logic [15:0] a2, input logic ovf,
                                               input logic [15:0] rate);
        sample_word_t w;
        w = '0;
        w.kind = KIND_SAMPLE;
        w.raw_axis_zero = a0;
        w.raw_axis_one = a1;
        w.raw_axis_two = a2;
        w.sensor_overflow = ovf;
        w.measured_rate = rate;
        return w;
    endfunction

    function automatic sample_word_t start_of(input logic [2:0] mask, input logic [15:0] len);
        sample_word_t w;
        w = '0;
        w.kind = KIND_START;
        w.axes_mask = mask;
        w.run_length = len;
        return w;
    endfunction

    function automatic sample_word_t random_item();
        sample_word_t w;
        w.axes_mask = 3'($urandom_range(0, 7));
        w.run_length = 16'($urandom());
        w.raw_axis_zero = pick_raw();
        w.raw_axis_one = pick_raw();
        w.raw_axis_two = pick_raw();
        w.sensor_overflow = ($urandom_range(0, 7) == 0);
        w.measured_rate = 16'($urandom());
        if (run_left == 0)
        begin
            w.kind = ($urandom_range(0, 9) != 0) ? KIND_START : KIND_SAMPLE;
            case ($urandom_range(0, 19))
                0:          w.run_length = 16'd0;
                1, 2, 3, 4: w.run_length = 16'($urandom_range(11, 40));
                default:    w.run_length = 16'($urandom_range(1, 10));
            endcase
        end
        else
        begin
            w.kind = ($urandom_range(0, 11) == 0) ? KIND_START : KIND_SAMPLE;
        end
        return w;
    endfunction

    task automatic send_word(input sample_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        sample_data <= w;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        burst_left--;
    endtask

    // track run state so ignored starts only land inside a run
    task automatic offer(input sample_word_t w);
        if (w.kind == KIND_START)
        begin
            if (run_left == 0 && w.run_length != 16'd0) run_left = w.run_length + 1;
        end
        else if (run_left > 0)
        begin
            run_left--;
        end
        send_word(w);
    endtask

    // expected_count is a registered copy of the checker's queue size
    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (expected_count != 0) @(posedge clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_registers(input logic [7:0] res, input logic [7:0] ori,
                                   input logic [7:0] cap);
        cfg_write <= 1'b1;
        cfg_index <= REG_RESOLUTION;
        cfg_data <= res;
        @(posedge clk);
        cfg_index <= REG_ORIENTATION;
        cfg_data <= ori;
        @(posedge clk);
        cfg_index <= REG_CAPACITY;
        cfg_data <= cap;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : receiver
        int mode;
        int mode_left;
        int served;
        int tick;
        result_ready <= 1'b0;
        mode = READY_ALWAYS;
        mode_left = 0;
        served = 0;
        tick = 0;
        @(posedge clk);
        forever
        begin
            if (hold_token != served)
            begin
                served++;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(READY_ALWAYS, READY_PERIODIC);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                tick++;
                case (mode)
                    READY_ALWAYS: result_ready <= 1'b1;
                    READY_HALF:   result_ready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: result_ready <= ($urandom_range(0, 5) != 0);
                    default:      result_ready <= (tick % 4 != 3);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
            || cfg_write)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("accel_sample_bit_packer_top: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample_data <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_RESOLUTION;
        cfg_data <= '0;
        hold_token <= 0;
        burst_left = 0;
        run_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle sample, empty run, ignored start, extremes
        offer(sample_of(16'h1111, 16'h2222, 16'h3333, 1'b1, 16'd50));
        offer(start_of(3'b111, 16'd0));
        offer(start_of(3'b111, 16'd3));
        offer(sample_of(16'h1234, 16'h5678, 16'h9ABC, 1'b1, 16'd100));
        offer(start_of(3'b010, 16'd9));
        offer(sample_of(16'h8000, 16'h7FFF, 16'h0000, 1'b0, 16'hFFFF));
        offer(sample_of(16'hFFFF, 16'h0001, 16'h8000, 1'b0, 16'h0001));
        offer(sample_of(16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, 16'h8000));
        settle();

        // full resolution, every axis inverted, one sample per packet
        write_registers(8'd16, 8'd46, 8'd1);
        offer(start_of(3'b111, 16'd4));
        offer(sample_of(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, 16'd10));
        offer(sample_of(16'h8000, 16'h8000, 16'h8000, 1'b1, 16'd20));
        offer(sample_of(16'h7FFF, 16'h0000, 16'hFFFF, 1'b0, 16'd30));
        offer(sample_of(16'h0001, 16'h8001, 16'h7FFE, 1'b1, 16'hFFFF));
        offer(sample_of(16'hFFFF, 16'h7FFF, 16'h0000, 1'b0, 16'h0000));
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       write_registers(8'd1, 8'd75, 8'd255);
                1:       write_registers(8'd0, 8'd1, 8'd0);
                2:       write_registers(8'd20, 8'd127, 8'd2);
                3:       write_registers(8'd16, 8'd52, 8'd5);
                default:
                begin
                    write_registers(8'($urandom_range(1, 16)),
                                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                                                : 8'($urandom_range(0, 69)),
                                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                : 8'($urandom_range(1, 8)));
                end
            endcase
            if (phase == 0) hold_token <= hold_token + 1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == PHASE_ITEMS / 2) wait_drained();
                offer(random_item());
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_count == 0)
        begin
            $display("accel_sample_bit_packer_top: match");
        end
        else
        begin
            $display("accel_sample_bit_packer_top: mismatch");
        end
        $finish;
    end

endmodule
